FILE: src/dsi_pkg.sv
// Shared types and constants for the decimal string to integer converter.
// Used by dsi_front, dsi_queue, dsi_back and decimal_string_to_integer.
// No dependencies.
package dsi_pkg;

  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned DIGIT_W       = 4;
  localparam int unsigned QUEUE_DEPTH_D = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  // Magnitude limits: 2^(width-1), the largest negative magnitude.
  localparam logic [VALUE_W-1:0] LIM_NARROW = 64'h0000_0000_8000_0000;
  localparam logic [VALUE_W-1:0] LIM_WIDE   = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] MASK_NARROW = 64'h0000_0000_FFFF_FFFF;

  // floor((lim - d) / 10): one value for digits 0..8, one less for digit 9.
  localparam logic [VALUE_W-1:0] THR_NARROW   = 64'h0000_0000_0CCC_CCCC;
  localparam logic [VALUE_W-1:0] THR_NARROW_9 = 64'h0000_0000_0CCC_CCCB;
  localparam logic [VALUE_W-1:0] THR_WIDE     = 64'h0CCC_CCCC_CCCC_CCCC;
  localparam logic [VALUE_W-1:0] THR_WIDE_9   = 64'h0CCC_CCCC_CCCC_CCCB;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE   = 4'd9;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_SPACE = 3'd1,
    CLS_PLUS  = 3'd2,
    CLS_MINUS = 3'd3,
    CLS_NUL   = 3'd4,
    CLS_OTHER = 3'd5
  } char_cls_t;

  typedef struct packed {
    char_cls_t          cls;
    logic [DIGIT_W-1:0] digit;
  } token_t;

  typedef enum logic [3:0] {
    PH_LEAD  = 4'b0001,
    PH_DIGIT = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_ERR   = 4'b1000
  } phase_t;

  // Threshold above which accumulating digit d passes the limit.
  function automatic logic [VALUE_W-1:0] digit_thr(input logic wide,
                                                   input logic [DIGIT_W-1:0] d);
    logic [VALUE_W-1:0] thr;
    if (wide) begin
      thr = (d == DIGIT_NINE) ? THR_WIDE_9 : THR_WIDE;
    end else begin
      thr = (d == DIGIT_NINE) ? THR_NARROW_9 : THR_NARROW;
    end
    return thr;
  endfunction

endpackage

FILE: src/dsi_front.sv
// Input side: accepts characters and classifies each into a token.
// Depends on dsi_pkg; feeds dsi_queue.
module dsi_front (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dsi_pkg::CHAR_W-1:0]  in_char_byte,
  input  logic                        q_ready,
  output logic                        q_push,
  output dsi_pkg::token_t             q_tok
);

  logic is_digit;
  logic is_space;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready;

  assign is_digit = (in_char_byte >= dsi_pkg::CH_ZERO) && (in_char_byte <= dsi_pkg::CH_NINE);
  assign is_space = (in_char_byte == dsi_pkg::CH_SPACE) ||
                    ((in_char_byte >= dsi_pkg::CH_TAB) && (in_char_byte <= dsi_pkg::CH_CR));

  always_comb begin
    q_tok.digit = dsi_pkg::DIGIT_W'(in_char_byte - dsi_pkg::CH_ZERO);
    if (in_char_byte == dsi_pkg::CH_NUL) begin
      q_tok.cls = dsi_pkg::CLS_NUL;
    end else if (is_digit) begin
      q_tok.cls = dsi_pkg::CLS_DIGIT;
    end else if (is_space) begin
      q_tok.cls = dsi_pkg::CLS_SPACE;
    end else if (in_char_byte == dsi_pkg::CH_PLUS) begin
      q_tok.cls = dsi_pkg::CLS_PLUS;
    end else if (in_char_byte == dsi_pkg::CH_MINUS) begin
      q_tok.cls = dsi_pkg::CLS_MINUS;
    end else begin
      q_tok.cls = dsi_pkg::CLS_OTHER;
    end
  end

endmodule

FILE: src/dsi_queue.sv
// Short token queue between the classifier and the accumulator.
// Depends on dsi_pkg for the token type.
module dsi_queue #(
  parameter int unsigned DEPTH = dsi_pkg::QUEUE_DEPTH_D
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  dsi_pkg::token_t push_tok,
  output logic            push_ready,
  output logic            pop_valid,
  input  logic            pop,
  output dsi_pkg::token_t pop_tok
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dsi_pkg::token_t  mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

FILE: src/dsi_back.sv
// Parse engine: runs the phase machine and accumulator on queued tokens and
// holds the result register. Depends on dsi_pkg.
module dsi_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wide_mode,
  input  logic                               tok_valid,
  input  dsi_pkg::token_t                    tok,
  output logic                               tok_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic signed [dsi_pkg::VALUE_W-1:0] out_value,
  output logic                               out_overflow
);

  localparam int unsigned VW = dsi_pkg::VALUE_W;

  dsi_pkg::phase_t  phase_r, phase_nxt;
  logic [VW-1:0]    acc_r, acc_nxt;
  logic             neg_r, neg_nxt;
  logic             wrap_r, wrap_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             ok_r, ok_nxt;
  logic [VW-1:0]    value_r, value_nxt;
  logic             ovf_r, ovf_nxt;

  logic             is_nul;
  logic [VW-1:0]    lim;
  logic [VW-1:0]    mask;
  logic [VW-1:0]    acc_x10d;
  logic             digit_wrap;
  logic [VW-1:0]    signed_mag;
  logic [VW-1:0]    fin_val;
  logic             fin_ok;
  logic             fin_ovf;

  assign is_nul  = (tok.cls == dsi_pkg::CLS_NUL);
  // A terminator waits for a free result slot; anything else moves straight on.
  assign tok_pop = tok_valid && (!is_nul || !out_valid_r || out_ready);

  assign lim  = wide_mode ? dsi_pkg::LIM_WIDE : dsi_pkg::LIM_NARROW;
  assign mask = wide_mode ? {VW{1'b1}} : dsi_pkg::MASK_NARROW;

  assign acc_x10d   = ({acc_r[VW-4:0], 3'b000} + {acc_r[VW-2:0], 1'b0} +
                       VW'(tok.digit)) & mask;
  assign digit_wrap = (acc_r > lim) || (acc_r > dsi_pkg::digit_thr(wide_mode, tok.digit));

  always_comb begin
    signed_mag = (neg_r ? (~acc_r + 1'b1) : acc_r) & mask;
    if (wide_mode) begin
      fin_val = signed_mag;
    end else begin
      fin_val = {{(VW-32){signed_mag[31]}}, signed_mag[31:0]};
    end
    fin_ok  = (phase_r != dsi_pkg::PH_ERR);
    fin_ovf = wrap_r || (acc_r > lim) || (!neg_r && (acc_r == lim));
  end

  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    neg_nxt       = neg_r;
    wrap_nxt      = wrap_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ok_nxt        = ok_r;
    value_nxt     = value_r;
    ovf_nxt       = ovf_r;
    if (tok_pop) begin
      if (is_nul) begin
        out_valid_nxt = 1'b1;
        ok_nxt        = fin_ok;
        value_nxt     = fin_ok ? fin_val : '0;
        ovf_nxt       = fin_ok && fin_ovf;
        phase_nxt     = dsi_pkg::PH_LEAD;
        acc_nxt       = '0;
        neg_nxt       = 1'b0;
        wrap_nxt      = 1'b0;
      end else begin
        case (phase_r)
          dsi_pkg::PH_LEAD: begin
            case (tok.cls)
              dsi_pkg::CLS_SPACE: phase_nxt = dsi_pkg::PH_LEAD;
              dsi_pkg::CLS_PLUS: begin
                neg_nxt   = 1'b0;
                phase_nxt = dsi_pkg::PH_DIGIT;
              end
              dsi_pkg::CLS_MINUS: begin
                neg_nxt   = 1'b1;
                phase_nxt = dsi_pkg::PH_DIGIT;
              end
              dsi_pkg::CLS_DIGIT: begin
                acc_nxt   = acc_x10d;
                wrap_nxt  = wrap_r || digit_wrap;
                phase_nxt = dsi_pkg::PH_DIGIT;
              end
              default: phase_nxt = dsi_pkg::PH_ERR;
            endcase
          end
          dsi_pkg::PH_DIGIT: begin
            case (tok.cls)
              dsi_pkg::CLS_DIGIT: begin
                acc_nxt  = acc_x10d;
                wrap_nxt = wrap_r || digit_wrap;
              end
              dsi_pkg::CLS_SPACE: phase_nxt = dsi_pkg::PH_TRAIL;
              default:            phase_nxt = dsi_pkg::PH_ERR;
            endcase
          end
          dsi_pkg::PH_TRAIL: begin
            if (tok.cls != dsi_pkg::CLS_SPACE) begin
              phase_nxt = dsi_pkg::PH_ERR;
            end
          end
          default: phase_nxt = dsi_pkg::PH_ERR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= dsi_pkg::PH_LEAD;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      wrap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      neg_r       <= neg_nxt;
      wrap_r      <= wrap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    value_r <= value_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = ok_r;
  assign out_value    = value_r;
  assign out_overflow = ovf_r;

endmodule

FILE: src/decimal_string_to_integer.sv
// Decimal string to signed integer converter, top level.
// Depends on dsi_pkg, dsi_front, dsi_queue and dsi_back.
//
// Takes one ASCII character per transaction and sustains one character per
// clock cycle while the token queue has room. Each character is classified
// on entry and held in a small token queue (QUEUE_DEPTH entries); the parse
// engine retires one token per cycle, computing value*10+digit combinationally.
// A NUL character produces one registered result transaction once it has
// passed the token queue. Only a terminator waiting for the result register
// to empty holds the engine; the queue then absorbs further characters until
// it fills. Results: ok, value (wrapped to 32 or 64 bits per cfg_wr_data of
// the last configuration write, sign-extended in 32-bit mode; zero when
// rejected) and overflow. Write the mode only while no string is in flight.
module decimal_string_to_integer #(
  parameter int unsigned QUEUE_DEPTH = dsi_pkg::QUEUE_DEPTH_D
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dsi_pkg::CHAR_W-1:0]         in_char_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic signed [dsi_pkg::VALUE_W-1:0] out_value,
  output logic                               out_overflow
);

  logic            wide_mode_r, wide_mode_nxt;
  logic            q_ready;
  logic            q_push;
  dsi_pkg::token_t q_in_tok;
  logic            q_valid;
  logic            q_pop;
  dsi_pkg::token_t q_out_tok;

  assign wide_mode_nxt = cfg_wr_en ? cfg_wr_data : wide_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_mode_r <= 1'b0;
    end else begin
      wide_mode_r <= wide_mode_nxt;
    end
  end

  dsi_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_tok        (q_in_tok)
  );

  dsi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_tok   (q_in_tok),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_tok    (q_out_tok)
  );

  dsi_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wide_mode    (wide_mode_r),
    .tok_valid    (q_valid),
    .tok          (q_out_tok),
    .tok_pop      (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_value    (out_value),
    .out_overflow (out_overflow)
  );

endmodule

FILE: tb/decimal_string_to_integer_tb.sv
// Testbench for decimal_string_to_integer: streams ASCII strings through the
// converter and checks every result against a built-in parse predictor.
// Depends on dsi_pkg and the decimal_string_to_integer RTL.
module decimal_string_to_integer_tb;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_CHARS = 1000;
  localparam int TIMEOUT      = 3_600_000;

  typedef struct {
    logic               ok;
    logic signed [63:0] value;
    logic               overflow;
  } conversion_t;

  logic                clk          = 1'b0;
  logic                rst_n        = 1'b0;
  logic                cfg_wr_en    = 1'b0;
  logic                cfg_wr_data  = 1'b0;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [7:0]          in_char_byte = 8'h00;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic                out_ok;
  logic signed [63:0]  out_value;
  logic                out_overflow;

  // parse predictor state
  dsi_pkg::phase_t scan_phase = dsi_pkg::PH_LEAD;
  logic [63:0]     magnitude  = '0;
  logic            minus_seen = 1'b0;
  logic            wrap_seen  = 1'b0;
  logic            wide_sel   = 1'b0;

  conversion_t awaited[$];

  int fail_count    = 0;
  int chars_sent    = 0;
  int strings_sent  = 0;
  int results_seen  = 0;
  int mode_writes   = 0;
  int burst_left    = 0;
  int max_gap       = 0;
  int ready_pct     = 100;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  decimal_string_to_integer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_value    (out_value),
    .out_overflow (out_overflow)
  );

  always #6 clk = ~clk;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == dsi_pkg::CH_SPACE) || (c >= dsi_pkg::CH_TAB && c <= dsi_pkg::CH_CR);
  endfunction

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= dsi_pkg::CH_ZERO) && (c <= dsi_pkg::CH_NINE);
  endfunction

  function automatic logic [7:0] pick_blank();
    logic [7:0] b;
    case ($urandom_range(5))
      0: b = dsi_pkg::CH_SPACE;
      1: b = dsi_pkg::CH_TAB;
      2: b = CH_LF;
      3: b = CH_VT;
      4: b = CH_FF;
      default: b = dsi_pkg::CH_CR;
    endcase
    return b;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Advance the parse by one accepted character; a NUL yields the awaited result.
  task automatic parse_char(input logic [7:0] c);
    logic [63:0] lim;
    logic [63:0] keep;
    logic [63:0] d;
    logic [63:0] v;
    conversion_t r;
    lim  = wide_sel ? dsi_pkg::LIM_WIDE : dsi_pkg::LIM_NARROW;
    keep = wide_sel ? {64{1'b1}} : dsi_pkg::MASK_NARROW;
    d    = {56'b0, c} - {56'b0, dsi_pkg::CH_ZERO};
    if (c == dsi_pkg::CH_NUL) begin
      r.ok = (scan_phase != dsi_pkg::PH_ERR);
      v = minus_seen ? (64'd0 - magnitude) : magnitude;
      v = v & keep;
      if (!wide_sel && v[31]) begin
        v[63:32] = '1;
      end
      r.value    = r.ok ? v : '0;
      r.overflow = r.ok && (wrap_seen || magnitude > lim || (!minus_seen && magnitude == lim));
      awaited.push_back(r);
      strings_sent++;
      scan_phase = dsi_pkg::PH_LEAD;
      magnitude  = '0;
      minus_seen = 1'b0;
      wrap_seen  = 1'b0;
    end else begin
      case (scan_phase)
        dsi_pkg::PH_LEAD: begin
          if (blank_char(c)) begin
            scan_phase = dsi_pkg::PH_LEAD;
          end else if (c == dsi_pkg::CH_PLUS || c == dsi_pkg::CH_MINUS) begin
            minus_seen = (c == dsi_pkg::CH_MINUS);
            scan_phase = dsi_pkg::PH_DIGIT;
          end else if (digit_char(c)) begin
            scan_phase = dsi_pkg::PH_DIGIT;
          end else begin
            scan_phase = dsi_pkg::PH_ERR;
          end
        end
        dsi_pkg::PH_DIGIT: begin
          if (blank_char(c)) begin
            scan_phase = dsi_pkg::PH_TRAIL;
          end else if (!digit_char(c)) begin
            scan_phase = dsi_pkg::PH_ERR;
          end
        end
        dsi_pkg::PH_TRAIL: begin
          if (!blank_char(c)) begin
            scan_phase = dsi_pkg::PH_ERR;
          end
        end
        default: scan_phase = dsi_pkg::PH_ERR;
      endcase
      // a digit is accumulated at the width in force now
      if (digit_char(c) && scan_phase == dsi_pkg::PH_DIGIT) begin
        if (magnitude > lim || magnitude > (lim - d) / 64'd10) begin
          wrap_seen = 1'b1;
        end
        magnitude = (magnitude * 64'd10 + d) & keep;
      end
    end
  endtask

  // Offer one character in bursts with random gaps; return once it is taken.
  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_char_byte <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    parse_char(c);
  endtask

  task automatic send_text(input string s, input logic terminate);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    if (terminate) begin
      send_char(dsi_pkg::CH_NUL);
    end
  endtask

  // Let the block go quiet before touching the mode bit.
  task automatic write_mode(input logic mode);
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wide_sel = mode;
    mode_writes++;
  endtask

  task automatic test_empty_and_sign();
    send_text("", 1'b1);
    send_text("-", 1'b1);
    send_text("+", 1'b1);
    send_char(dsi_pkg::CH_SPACE);
    send_char(dsi_pkg::CH_MINUS);
    send_char(dsi_pkg::CH_TAB);
    send_char(dsi_pkg::CH_NUL);
  endtask

  task automatic test_whitespace();
    send_char(dsi_pkg::CH_TAB);
    send_char(CH_LF);
    send_char(CH_VT);
    send_char(CH_FF);
    send_char(dsi_pkg::CH_CR);
    send_char(dsi_pkg::CH_NINE);
    send_char(dsi_pkg::CH_SPACE);
    send_char(dsi_pkg::CH_NUL);
  endtask

  task automatic test_rejected();
    send_text("1x", 1'b1);
    send_text("+-1", 1'b1);
    send_text("1 2", 1'b1);
    send_char(8'hFF);
    send_char(dsi_pkg::CH_NUL);
    send_char(8'h80);
    send_text("5", 1'b1);
  endtask

  task automatic test_mode_switch_mid_string();
    write_mode(1'b0);
    send_text("+99999", 1'b0);
    write_mode(1'b1);
    send_text("99999", 1'b1);
    send_text("5000000000", 1'b0);
    write_mode(1'b0);
    send_char(dsi_pkg::CH_NUL);
  endtask

  // Hold the result side off while characters keep coming, so the queue fills.
  task automatic test_backpressure();
    ready_pct <= 100;
    max_gap = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (16) begin
      send_text($sformatf("-%0d", $urandom_range(99)), 1'b1);
    end
  endtask

  task automatic test_random_strings(input int target);
    logic [7:0]  txt[$];
    logic [63:0] u;
    logic [7:0]  b;
    string       digits;
    int          kind;
    int          stop_at;
    stop_at = chars_sent + target;
    while (chars_sent < stop_at) begin
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(3))
          0: ready_pct <= 100;
          1: ready_pct <= 85;
          2: ready_pct <= 50;
          default: ready_pct <= 25;
        endcase
        max_gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if ($urandom_range(19) == 0) begin
        write_mode(1'($urandom_range(1)));
      end
      txt.delete();
      digits = "";
      repeat ($urandom_range(2)) txt.push_back(pick_blank());
      case ($urandom_range(2))
        1: txt.push_back(dsi_pkg::CH_PLUS);
        2: txt.push_back(dsi_pkg::CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 3)) txt.push_back(dsi_pkg::CH_ZERO);
      end
      case ($urandom_range(8))
        0: digits = $sformatf("%0d", $urandom_range(999));
        1: digits = $sformatf("%0d", $urandom);
        2: begin
          u = {$urandom, $urandom};
          digits = $sformatf("%0d", u);
        end
        3: begin
          u = dsi_pkg::LIM_NARROW - 64'd3 + $urandom_range(6);
          digits = $sformatf("%0d", u);
        end
        4: begin
          u = dsi_pkg::LIM_WIDE - 64'd3 + $urandom_range(6);
          digits = $sformatf("%0d", u);
        end
        5: begin
          u = dsi_pkg::MASK_NARROW - 64'd1 + $urandom_range(3);
          digits = $sformatf("%0d", u);
        end
        6: begin
          u = {64{1'b1}} - $urandom_range(3);
          digits = $sformatf("%0d", u);
        end
        7: begin
          b = dsi_pkg::CH_ZERO + 8'($urandom_range(1, 9));
          txt.push_back(b);
          repeat ($urandom_range(20, 24)) begin
            b = dsi_pkg::CH_ZERO + 8'($urandom_range(9));
            txt.push_back(b);
          end
        end
        default: ;
      endcase
      for (int i = 0; i < digits.len(); i++) begin
        txt.push_back(digits[i]);
      end
      repeat ($urandom_range(2)) txt.push_back(pick_blank());
      kind = $urandom_range(99);
      if (kind >= 90) begin
        txt.delete();
        repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(1, 255)));
      end else if (kind >= 75) begin
        txt.insert($urandom_range(txt.size()), 8'($urandom_range(1, 255)));
      end
      foreach (txt[i]) send_char(txt[i]);
      send_char(dsi_pkg::CH_NUL);
    end
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_served) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_reqs;
    end else begin
      out_ready <= ($urandom_range(99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    conversion_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        note_failure($sformatf("unexpected result ok=%0b value=%0d overflow=%0b",
                               out_ok, out_value, out_overflow));
      end else begin
        e = awaited.pop_front();
        if (out_ok !== e.ok) begin
          note_failure($sformatf("ok: expected %0b, got %0b", e.ok, out_ok));
        end
        if (out_value !== e.value) begin
          note_failure($sformatf("value: expected %0d, got %0d", e.value, out_value));
        end
        if (out_overflow !== e.overflow) begin
          note_failure($sformatf("overflow: expected %0b, got %0b",
                                 e.overflow, out_overflow));
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    ready_pct <= 70;
    max_gap = 3;
    test_empty_and_sign();
    test_whitespace();
    test_rejected();
    test_mode_switch_mid_string();
    test_backpressure();
    test_random_strings(RANDOM_CHARS);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d strings, %0d characters, %0d results checked.",
             strings_sent, chars_sent, results_seen);
    $display("Both widths, %0d mode writes, long result hold-off, %0d mismatches.",
             mode_writes, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("Timeout with %0d results outstanding", awaited.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: decimal_string_to_integer.f
src/dsi_pkg.sv
src/dsi_front.sv
src/dsi_queue.sv
src/dsi_back.sv
src/decimal_string_to_integer.sv
tb/decimal_string_to_integer_tb.sv
